// ----- rtl/tsq_pkg.sv -----
package tsq_pkg;

  // payload widths fixed by the request and response formats
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int OCC_W  = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_XFER,
    S_RDWAIT,
    S_DONE
  } state_e;

  // one finished response word
  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_full;
  } res_t;

endpackage

// ----- rtl/tsq_ifs.sv -----
// request channel
interface tsq_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic signed [tsq_pkg::DATA_W-1:0] push_value;
  logic [tsq_pkg::POS_W-1:0]        position;

  modport source(output valid, req_type, push_value, position, input ready);
  modport sink(input valid, req_type, push_value, position, output ready);
endinterface

// response channel
interface tsq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [tsq_pkg::DATA_W-1:0] read_data;
  logic [1:0]                       status;
  logic [tsq_pkg::OCC_W-1:0]        occupancy;
  logic                             is_full;

  modport source(output valid, read_data, status, occupancy, is_full, input ready);
  modport sink(input valid, read_data, status, occupancy, is_full, output ready);
endinterface

// ----- rtl/two_stack_queue_core.sv -----
// FIFO of 32-bit words kept as two stacks (input and output), each
// STACK_DEPTH entries, held in two one-port-write, one-port-read RAMs.
// Request channel (req): req_type 0 enqueue, 1 dequeue, 2 peek at position,
// 3 no operation. Response channel (rsp): one word per request with
// read_data, status, occupancy and is_full after the request.
// Requests are taken one at a time; req.ready is high only while the
// controller is idle. A request is accepted even while the previous
// response still sits in the output register.
// The response for an enqueue, no-op or error result is loaded from DONE
// straight after EXEC; a dequeue or peek passes through RDWAIT first,
// which waits on the registered RAM read. With rsp.ready high the next
// request is accepted once the controller is back in IDLE.
// When an enqueue finds the input stack full and the output stack empty,
// or a dequeue finds the output stack empty and the input stack not, the
// input stack is first moved onto the output stack, one entry per cycle.
// Reset clears both stack counts and the output valid flag; the RAM contents
// are left as they are and never read below a count.
// If rsp.ready stays low the finished response waits in the controller and
// no further request is accepted until the output register frees up.
module two_stack_queue_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  tsq_req_if.sink    req,
  tsq_rsp_if.source  rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = tsq_pkg::DATA_W;

  logic          in_we, out_we;
  logic [AW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
  logic [DW-1:0] in_wdata, in_rdata, out_wdata, out_rdata;
  logic          slot_free, res_load;
  tsq_pkg::res_t res;

  logic          out_valid;
  tsq_pkg::res_t out_word;

  // input stack storage
  tsq_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  // output stack storage
  tsq_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  tsq_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .in_we     (in_we),
    .in_waddr  (in_waddr),
    .in_wdata  (in_wdata),
    .in_raddr  (in_raddr),
    .in_rdata  (in_rdata),
    .out_we    (out_we),
    .out_waddr (out_waddr),
    .out_wdata (out_wdata),
    .out_raddr (out_raddr),
    .out_rdata (out_rdata)
  );

  // output register
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_word.read_data;
  assign rsp.status    = out_word.status;
  assign rsp.occupancy = out_word.occupancy;
  assign rsp.is_full   = out_word.is_full;

  // a waiting response is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !res_load)
    else $error("response register overwritten while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while one is in flight");

  // overflow is only reported with the queue full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == tsq_pkg::ST_OVERFLOW) |-> rsp.is_full)
    else $error("overflow reported with queue not full");

  // underflow is only reported on an empty queue and returns zero
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == tsq_pkg::ST_UNDERFLOW)
      |-> (rsp.occupancy == '0 && rsp.read_data == '0))
    else $error("underflow reported with words held");

endmodule

// ----- rtl/tsq_ram.sv -----
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tsq_ctrl.sv -----
module tsq_ctrl #(
  parameter int STACK_DEPTH = 16,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int DW = tsq_pkg::DATA_W
) (
  input  logic             clk,
  input  logic             rst,
  tsq_req_if.sink          req,
  input  logic             slot_free,
  output logic             res_load,
  output tsq_pkg::res_t    res,
  // input stack memory
  output logic             in_we,
  output logic [AW-1:0]    in_waddr,
  output logic [DW-1:0]    in_wdata,
  output logic [AW-1:0]    in_raddr,
  input  logic [DW-1:0]    in_rdata,
  // output stack memory
  output logic             out_we,
  output logic [AW-1:0]    out_waddr,
  output logic [DW-1:0]    out_wdata,
  output logic [AW-1:0]    out_raddr,
  input  logic [DW-1:0]    out_rdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int TW = (CW + 1 > tsq_pkg::POS_W) ? CW + 1 : tsq_pkg::POS_W;
  localparam int OW = tsq_pkg::OCC_W;

  tsq_pkg::state_e  state, state_next;
  tsq_pkg::req_e    op;
  logic [DW-1:0]    val;
  logic [tsq_pkg::POS_W-1:0] pos;
  logic [CW-1:0]    in_count, out_count;
  logic [CW-1:0]    xk;
  logic             pend;
  logic [AW-1:0]    xfer_waddr;
  logic             rd_from_out;
  logic signed [DW-1:0] data;
  tsq_pkg::status_e stat;

  logic [TW-1:0] total, pos_ext;
  logic          full, in_at_top, xfer_end, peek_bad, peek_out;

  assign total     = TW'(out_count) + TW'(in_count);
  assign pos_ext   = TW'(pos);
  assign in_at_top = (in_count == CW'(STACK_DEPTH));
  assign full      = (out_count != '0) && in_at_top;
  assign xfer_end  = (xk == in_count) && !pend;
  assign peek_bad  = (pos_ext >= total);
  assign peek_out  = (pos_ext < TW'(out_count));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsq_pkg::S_IDLE: begin
        if (req.valid) state_next = tsq_pkg::S_EXEC;
      end
      tsq_pkg::S_EXEC: begin
        case (op)
          tsq_pkg::REQ_ENQ: begin
            if (!full && in_at_top) state_next = tsq_pkg::S_XFER;
            else state_next = tsq_pkg::S_DONE;
          end
          tsq_pkg::REQ_DEQ: begin
            if (total == '0) state_next = tsq_pkg::S_DONE;
            else if (out_count == '0) state_next = tsq_pkg::S_XFER;
            else state_next = tsq_pkg::S_RDWAIT;
          end
          tsq_pkg::REQ_PEEK: begin
            if (peek_bad) state_next = tsq_pkg::S_DONE;
            else state_next = tsq_pkg::S_RDWAIT;
          end
          default: state_next = tsq_pkg::S_DONE;
        endcase
      end
      tsq_pkg::S_XFER: begin
        if (xfer_end) state_next = tsq_pkg::S_EXEC;
      end
      tsq_pkg::S_RDWAIT: state_next = tsq_pkg::S_DONE;
      tsq_pkg::S_DONE: begin
        if (slot_free) state_next = tsq_pkg::S_IDLE;
      end
      default: state_next = tsq_pkg::S_IDLE;
    endcase
  end

  // handshake and memory port outputs
  always_comb begin
    req.ready = (state == tsq_pkg::S_IDLE);
    res_load  = (state == tsq_pkg::S_DONE) && slot_free;

    // push goes straight to the top of the input stack
    in_we    = (state == tsq_pkg::S_EXEC) && (op == tsq_pkg::REQ_ENQ) && !full && !in_at_top;
    in_waddr = AW'(in_count);
    in_wdata = val;

    // transfer reads the input stack from the top down, peek reads it from the bottom
    if (state == tsq_pkg::S_XFER) begin
      in_raddr = AW'(in_count - CW'(1) - xk);
    end else begin
      in_raddr = AW'(pos_ext - TW'(out_count));
    end

    // transfer writes the output stack in the cycle after its read
    out_we    = (state == tsq_pkg::S_XFER) && pend;
    out_waddr = xfer_waddr;
    out_wdata = in_rdata;

    if (op == tsq_pkg::REQ_DEQ) begin
      out_raddr = AW'(out_count - CW'(1));
    end else begin
      out_raddr = AW'(TW'(out_count) - TW'(1) - pos_ext);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stack counts
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else if (state == tsq_pkg::S_EXEC) begin
      if (in_we) in_count <= in_count + CW'(1);
      if (op == tsq_pkg::REQ_DEQ && out_count != '0) out_count <= out_count - CW'(1);
    end else if (state == tsq_pkg::S_XFER && xfer_end) begin
      out_count <= in_count;
      in_count  <= '0;
    end
  end

  // transfer sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      xk   <= '0;
      pend <= 1'b0;
    end else if (state == tsq_pkg::S_EXEC) begin
      xk   <= '0;
      pend <= 1'b0;
    end else if (state == tsq_pkg::S_XFER) begin
      if (xk != in_count) begin
        xk   <= xk + CW'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // request and result holding registers
  always_ff @(posedge clk) begin
    if (state == tsq_pkg::S_IDLE && req.valid) begin
      op  <= tsq_pkg::req_e'(req.req_type);
      val <= req.push_value;
      pos <= req.position;
    end
    if (state == tsq_pkg::S_XFER) begin
      xfer_waddr <= AW'(xk);
    end
    if (state == tsq_pkg::S_EXEC) begin
      data <= '0;
      stat <= tsq_pkg::ST_OK;
      case (op)
        tsq_pkg::REQ_ENQ: begin
          if (full) stat <= tsq_pkg::ST_OVERFLOW;
        end
        tsq_pkg::REQ_DEQ: begin
          if (total == '0) stat <= tsq_pkg::ST_UNDERFLOW;
          rd_from_out <= 1'b1;
        end
        tsq_pkg::REQ_PEEK: begin
          if (peek_bad) stat <= tsq_pkg::ST_RANGE;
          rd_from_out <= peek_out;
        end
        default: stat <= tsq_pkg::ST_OK;
      endcase
    end
    if (state == tsq_pkg::S_RDWAIT) begin
      data <= rd_from_out ? out_rdata : in_rdata;
    end
  end

  // response word, counts are final by the time it is loaded
  always_comb begin
    res.read_data = data;
    res.status    = stat;
    res.occupancy = OW'(total);
    res.is_full   = full;
  end

endmodule
